// ===== hw/rtl/quadrature_detent_level_control_macros.svh =====
// Assertion helpers shared by the front end, queue and back end RTL files.
`ifndef QUADRATURE_DETENT_LEVEL_CONTROL_MACROS_SVH
`define QUADRATURE_DETENT_LEVEL_CONTROL_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define QDLC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QDLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/qdlc_pkg.sv =====
package qdlc_pkg;

   localparam int unsigned LEVEL_MAX  = 100;
   localparam int unsigned LEVEL_W    = 7;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned FIFO_DEPTH = 2;

   // floor(x / LEVEL_MAX) as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^23
   localparam int unsigned RECIP_SHIFT = 30;
   localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;
   localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
   localparam int unsigned PRODUCT_W   = PERIOD_W + LEVEL_W;
   localparam int unsigned SCALED_W    = PRODUCT_W + RECIP_W;

   localparam logic [LEVEL_W-1:0]  LEVEL_TOP         = LEVEL_W'(LEVEL_MAX);
   localparam logic [LEVEL_W-1:0]  LEVEL_HALF        = LEVEL_W'(LEVEL_MAX / 2);
   localparam logic [LEVEL_W-1:0]  LEVEL_STEP_RESET  = 7'd10;
   localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RESET   = 7'd0;
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET  = 16'd1000;

   typedef enum logic [1:0] {
      CSR_LEVEL_STEP = 2'd0,
      CSR_MIN_LEVEL  = 2'd1,
      CSR_PWM_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               turned_cw;
      logic               turned_ccw;
   } detent_type;

   // Position of (A,B) along the clockwise sequence 00, 10, 11, 01.
   function automatic logic [1:0] gray_pos(input logic [1:0] ab);
      logic [1:0] pos;
      unique case (ab)
         2'b00: pos = 2'd0;
         2'b01: pos = 2'd3;
         2'b10: pos = 2'd1;
         2'b11: pos = 2'd2;
      endcase
      return pos;
   endfunction

endpackage

// ===== hw/rtl/qdlc_front.sv =====
`include "quadrature_detent_level_control_macros.svh"

module qdlc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sample_valid,
   input  logic                          sample_a,
   input  logic                          sample_b,
   output logic                          sample_ready,
   input  logic                          space_avail,
   input  logic [qdlc_pkg::LEVEL_W-1:0]  level_step,
   input  logic [qdlc_pkg::LEVEL_W-1:0]  min_level,
   output logic                          push,
   output qdlc_pkg::detent_type          push_data
);
   import qdlc_pkg::*;

   logic [2:0]         phase_ff, phase_in;
   logic [2:0]         count_ff, count_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               accept;
   logic [1:0]         ab;
   logic [1:0]         delta;
   logic signed [3:0]  count_next;
   logic [LEVEL_W:0]   level_sum;
   logic [LEVEL_W-1:0] level_gap;
   logic               cw, ccw;

   assign sample_ready = space_avail;
   assign accept       = sample_valid && space_avail;
   assign ab           = {sample_a, sample_b};
   assign delta        = gray_pos(ab) - gray_pos(phase_ff[1:0]);
   assign level_sum    = {1'b0, level_ff} + {1'b0, level_step};
   assign level_gap    = level_ff - min_level;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      level_in   = level_ff;
      cw         = 1'b0;
      ccw        = 1'b0;
      count_next = {count_ff[2], count_ff};
      if (accept) begin
         if (!phase_ff[2]) begin
            // first sample: lock onto the phase only
            phase_in = {1'b1, ab};
            count_in = '0;
            level_in = LEVEL_HALF;
         end else begin
            if (delta == 2'd1) begin
               count_next = count_next + 4'sd1;
               phase_in   = {1'b1, ab};
            end else if (delta == 2'd3) begin
               count_next = count_next - 4'sd1;
               phase_in   = {1'b1, ab};
            end
            if (count_next >= 4'sd4) begin
               count_in = '0;
               cw       = 1'b1;
               if (level_ff < LEVEL_TOP) begin
                  level_in = (level_sum > {1'b0, LEVEL_TOP}) ? LEVEL_TOP
                                                            : level_sum[LEVEL_W-1:0];
               end
            end else if (count_next <= -4'sd4) begin
               count_in = '0;
               ccw      = 1'b1;
               if (level_ff > min_level) begin
                  level_in = (level_gap > level_step) ? level_ff - level_step : min_level;
               end
            end else begin
               count_in = count_next[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
         level_ff <= LEVEL_HALF;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

   assign push                 = accept;
   assign push_data.level      = level_in;
   assign push_data.turned_cw  = cw;
   assign push_data.turned_ccw = ccw;

   `QDLC_ASSERT_ALWAYS(a_level_in_range, level_ff <= LEVEL_TOP, "qdlc: level above maximum")
   `QDLC_ASSERT_NEXT(a_detent_clears_count, push && (cw || ccw), count_ff == 3'd0,
                     "qdlc: step count not cleared after detent")

endmodule

// ===== hw/rtl/qdlc_fifo.sv =====
`include "quadrature_detent_level_control_macros.svh"

module qdlc_fifo #(
   parameter int unsigned DEPTH = qdlc_pkg::FIFO_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qdlc_pkg::detent_type push_data,
   output logic                 space_avail,
   input  logic                 pop,
   output logic                 pop_valid,
   output qdlc_pkg::detent_type pop_data
);
   import qdlc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   detent_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign space_avail = (count_ff != CNT_FULL);
   assign pop_valid   = (count_ff != '0);
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `QDLC_ASSERT_ALWAYS(a_fifo_bounded, count_ff <= CNT_FULL, "qdlc: queue count out of range")
   `QDLC_ASSERT_ALWAYS(a_fifo_no_overflow, !push || space_avail, "qdlc: push into full queue")

endmodule

// ===== hw/rtl/qdlc_back.sv =====
`include "quadrature_detent_level_control_macros.svh"

module qdlc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  qdlc_pkg::detent_type          item_data,
   output logic                          item_pop,
   input  logic [qdlc_pkg::PERIOD_W-1:0] pwm_period,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata
);
   import qdlc_pkg::*;

   logic                  mul_valid_ff;
   detent_type            mul_item_ff;
   logic [PRODUCT_W-1:0]  product_ff;
   logic                  out_valid_ff;
   detent_type            out_item_ff;
   logic [PERIOD_W-1:0]   compare_ff;
   logic                  out_ready;
   logic                  mul_ready;
   logic [SCALED_W-1:0]   scaled;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign mul_ready = !mul_valid_ff || out_ready;
   assign item_pop  = item_valid && mul_ready;
   assign scaled    = SCALED_W'(product_ff) * SCALED_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= item_valid;
         end
         if (out_ready) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         mul_item_ff <= item_data;
         product_ff  <= PRODUCT_W'(pwm_period) * PRODUCT_W'(item_data.level);
      end
      if (out_ready && mul_valid_ff) begin
         out_item_ff <= mul_item_ff;
         compare_ff  <= scaled[RECIP_SHIFT +: PERIOD_W];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_item_ff.turned_ccw, out_item_ff.turned_cw,
                        compare_ff, out_item_ff.level};

   `QDLC_ASSERT_NEXT(a_mul_holds, mul_valid_ff && !out_ready, mul_valid_ff,
                     "qdlc: multiply stage dropped a stalled item")

endmodule

// ===== hw/rtl/quadrature_detent_level_control.sv =====
// A sample's result is registered in the queue, the multiply stage and the output stage before rsp.
// Throughput: one sample per cycle while the queue has space, set by the phase/level update in the
// front end; the back end scales in two registered multiply stages.
// A two-entry queue and the output register let each side stall on its own.
// Reset (synchronous, active high): phase unsynchronized, step count zero, level at half
// of maximum, registers back to their defaults, queue and pipeline empty.
module quadrature_detent_level_control #(
   parameter int unsigned FIFO_DEPTH = qdlc_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] chan_a, [1] chan_b
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] pwm_level, [22:7] compare_value,
                                    // [23] turned_cw, [24] turned_ccw
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import qdlc_pkg::*;

   logic [LEVEL_W-1:0]  level_step_ff;
   logic [LEVEL_W-1:0]  min_level_ff;
   logic [PERIOD_W-1:0] pwm_period_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   logic       push;
   detent_type push_data;
   logic       space_avail;
   logic       pop;
   logic       pop_valid;
   detent_type pop_data;

   // Register port: zero wait states; writes land on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_step_ff <= LEVEL_STEP_RESET;
         min_level_ff  <= MIN_LEVEL_RESET;
         pwm_period_ff <= PWM_PERIOD_RESET;
      end else if (csr_write) begin
         // drop writes to addresses beyond the register list
         unique case (csr_index)
            CSR_LEVEL_STEP: level_step_ff <= csr_pwdata[LEVEL_W-1:0];
            CSR_MIN_LEVEL:  min_level_ff  <= csr_pwdata[LEVEL_W-1:0];
            CSR_PWM_PERIOD: pwm_period_ff <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LEVEL_STEP: csr_prdata = {25'd0, level_step_ff};
         CSR_MIN_LEVEL:  csr_prdata = {25'd0, min_level_ff};
         CSR_PWM_PERIOD: csr_prdata = {16'd0, pwm_period_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Front end: track the gray-code phase, count steps, move the level per detent.
   qdlc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (req_tvalid),
      .sample_a     (req_tdata[0]),
      .sample_b     (req_tdata[1]),
      .sample_ready (req_tready),
      .space_avail  (space_avail),
      .level_step   (level_step_ff),
      .min_level    (min_level_ff),
      .push         (push),
      .push_data    (push_data)
   );

   // Hold finished level updates until the scaler takes them.
   qdlc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .space_avail (space_avail),
      .pop         (pop),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data)
   );

   // Back end: compare value = floor(pwm_period * level / LEVEL_MAX), then the output register.
   qdlc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_data  (pop_data),
      .item_pop   (pop),
      .pwm_period (pwm_period_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
